>>> sv/xmr_pkg.sv
// XMODEM checksum receiver: shared types, codes and constants.
// No dependencies; imported by every module of the receiver.
package xmr_pkg;

  // Payload bytes per packet and derived counter width
  localparam int unsigned PAYLOAD_BYTES = 128;
  localparam int unsigned CNT_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PAYLOAD_BYTES - 1);

  // Queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Protocol bytes
  localparam logic [7:0] SOH_BYTE = 8'h01;
  localparam logic [7:0] EOT_BYTE = 8'h04;

  // Register map and reset values
  localparam logic CFG_HEADER_WAIT = 1'b0;
  localparam logic CFG_BYTE_WAIT   = 1'b1;
  localparam logic [15:0] HEADER_WAIT_RST = 16'd10;
  localparam logic [15:0] BYTE_WAIT_RST   = 16'd1000;

  // Input commands on tuser
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_TICK  = 2'd2
  } xmr_cmd_e;

  // Classified operation handed to the back end
  typedef enum logic [1:0] {
    OP_START,
    OP_BYTE,
    OP_TICK
  } xmr_op_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_SEQ,
    PH_INVSEQ,
    PH_DATA,
    PH_SUM,
    PH_DONE,
    PH_FAILED
  } xmr_phase_e;

  typedef enum logic [1:0] {
    RSP_ACK = 2'd0,
    RSP_NAK = 2'd1,
    RSP_CAN = 2'd2
  } xmr_rsp_e;

  typedef enum logic [2:0] {
    V_STARTED  = 3'd0,
    V_ACCEPTED = 3'd1,
    V_REJECTED = 3'd2,
    V_COMPLETE = 3'd3,
    V_FAILED   = 3'd4
  } xmr_verdict_e;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_RESP = 1'b1
  } xmr_kind_e;

  // Queue entry
  typedef struct packed {
    xmr_op_e    op;
    logic [7:0] rx_byte;
    logic       is_soh;
    logic       is_eot;
  } xmr_item_t;

  // Result item
  typedef struct packed {
    xmr_kind_e    kind;
    logic [7:0]   data_byte;
    xmr_rsp_e     response;
    xmr_verdict_e verdict;
    logic [7:0]   packet_number;
  } xmr_result_t;

  // Queue status toward the front
  typedef struct packed {
    logic full;
    logic empty;
  } xmr_qstat_t;

endpackage

>>> sv/xmr_front.sv
// XMODEM receiver front end: accepts input items and classifies them.
// Depends on xmr_pkg; pushes into xmr_queue.
module xmr_front (
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,  // [7:0] rx_byte
  input  logic [1:0]        s_axis_tuser,  // [1:0] command
  input  xmr_pkg::xmr_qstat_t qstat_i,
  output logic              push_o,
  output xmr_pkg::xmr_item_t item_o
);
  import xmr_pkg::*;

  logic keep;

  // Take an item whenever the queue has room
  assign s_axis_tready = !qstat_i.full;

  // Decode command; the unused code is accepted and dropped
  always_comb begin
    keep    = 1'b1;
    item_o.op = OP_TICK;
    unique case (xmr_cmd_e'(s_axis_tuser))
      CMD_START: item_o.op = OP_START;
      CMD_BYTE:  item_o.op = OP_BYTE;
      CMD_TICK:  item_o.op = OP_TICK;
      default:   keep = 1'b0;
    endcase
    item_o.rx_byte = s_axis_tdata;
    item_o.is_soh  = (s_axis_tdata == SOH_BYTE);
    item_o.is_eot  = (s_axis_tdata == EOT_BYTE);
  end

  assign push_o = s_axis_tvalid && s_axis_tready && keep;

endmodule

>>> sv/xmr_queue.sv
// XMODEM receiver queue: short FIFO of classified items between front and back.
// Depends on xmr_pkg.
module xmr_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  xmr_pkg::xmr_item_t push_item_i,
  input  logic               pop_i,
  output xmr_pkg::xmr_item_t head_o,
  output xmr_pkg::xmr_qstat_t qstat_o
);
  import xmr_pkg::*;

  xmr_item_t           mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;

  assign qstat_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign qstat_o.empty = (cnt_q == '0);
  assign head_o        = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("queue fill count out of range");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("pop from empty queue");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |-> cnt_q != QCNT_W'(QDEPTH))
    else $error("push into full queue");
`endif

endmodule

>>> sv/xmr_back.sv
// XMODEM receiver back end: protocol state machine, timers and result register.
// Depends on xmr_pkg; pops items from xmr_queue.
module xmr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  xmr_pkg::xmr_item_t item_i,
  input  xmr_pkg::xmr_qstat_t qstat_i,
  output logic               pop_o,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output xmr_pkg::xmr_result_t res_o
);
  import xmr_pkg::*;

  logic [15:0] hdr_wait_q, byte_wait_q;
  xmr_phase_e  phase_q, phase_d;
  logic [7:0]  exp_q, exp_d;
  logic        mism_q, mism_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]  sum_q, sum_d;
  logic [15:0] wc_q, wc_d;
  logic        vld_q, vld_d;
  xmr_result_t res_q, res_d;

  logic        step;
  logic        active;
  logic        emit;
  xmr_result_t res;
  logic [15:0] wc_inc;
  logic [15:0] limit;

  // Work on the queue head when the result register can take the outcome
  assign step   = !qstat_i.empty && (!vld_q || res_ready_i);
  assign pop_o  = step;
  assign active = (phase_q != PH_IDLE) && (phase_q != PH_DONE) && (phase_q != PH_FAILED);
  assign wc_inc = (wc_q == 16'hFFFF) ? wc_q : wc_q + 16'd1;
  assign limit  = (phase_q == PH_HEADER) ? hdr_wait_q : byte_wait_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_wait_q  <= HEADER_WAIT_RST;
      byte_wait_q <= BYTE_WAIT_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_HEADER_WAIT) begin
        hdr_wait_q <= cfg_data_i;
      end else begin
        byte_wait_q <= cfg_data_i;
      end
    end
  end

  // Protocol next state and result
  always_comb begin
    phase_d = phase_q;
    exp_d   = exp_q;
    mism_d  = mism_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    wc_d    = wc_q;
    emit    = 1'b0;
    res     = '0;
    res.kind          = KIND_RESP;
    res.packet_number = exp_q;
    if (step) begin
      unique case (item_i.op)
        OP_START: begin
          exp_d   = 8'd1;
          mism_d  = 1'b0;
          cnt_d   = '0;
          sum_d   = '0;
          wc_d    = '0;
          phase_d = PH_HEADER;
          emit    = 1'b1;
          res.response      = RSP_NAK;
          res.verdict       = V_STARTED;
          res.packet_number = 8'd1;
        end
        OP_TICK: begin
          if (active) begin
            if (wc_inc < limit) begin
              wc_d = wc_inc;
            end else begin
              wc_d         = '0;
              emit         = 1'b1;
              res.response = RSP_CAN;
              if (phase_q == PH_HEADER) begin
                phase_d     = PH_FAILED;
                res.verdict = V_FAILED;
              end else begin
                phase_d     = PH_HEADER;
                res.verdict = V_REJECTED;
              end
            end
          end
        end
        OP_BYTE: begin
          if (active) begin
            wc_d = '0;
            unique case (phase_q)
              PH_HEADER: begin
                if (item_i.is_soh) begin
                  phase_d = PH_SEQ;
                  mism_d  = 1'b0;
                  cnt_d   = '0;
                  sum_d   = '0;
                end else if (item_i.is_eot) begin
                  phase_d      = PH_DONE;
                  emit         = 1'b1;
                  res.response = RSP_ACK;
                  res.verdict  = V_COMPLETE;
                end else begin
                  phase_d      = PH_FAILED;
                  emit         = 1'b1;
                  res.response = RSP_NAK;
                  res.verdict  = V_FAILED;
                end
              end
              PH_SEQ: begin
                mism_d  = (item_i.rx_byte != exp_q);
                phase_d = PH_INVSEQ;
              end
              PH_INVSEQ: begin
                if (item_i.rx_byte != ~exp_q) begin
                  mism_d = 1'b1;
                end
                cnt_d   = '0;
                sum_d   = '0;
                phase_d = PH_DATA;
              end
              PH_DATA: begin
                emit          = 1'b1;
                res.kind      = KIND_DATA;
                res.data_byte = item_i.rx_byte;
                sum_d         = sum_q + item_i.rx_byte;
                cnt_d         = cnt_q + 1'b1;
                if (cnt_q == CNT_LAST) begin
                  phase_d = PH_SUM;
                end
              end
              PH_SUM: begin
                phase_d      = PH_HEADER;
                emit         = 1'b1;
                if (mism_q || (sum_q != item_i.rx_byte)) begin
                  res.response = RSP_CAN;
                  res.verdict  = V_REJECTED;
                end else begin
                  res.response = RSP_ACK;
                  res.verdict  = V_ACCEPTED;
                  exp_d        = exp_q + 8'd1;
                end
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // Output register: loads on a step, empties when taken
  always_comb begin
    vld_d = vld_q;
    res_d = res_q;
    if (step) begin
      vld_d = emit;
      res_d = res;
    end else if (res_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      exp_q   <= 8'd1;
      mism_q  <= 1'b0;
      cnt_q   <= '0;
      sum_q   <= '0;
      wc_q    <= '0;
      vld_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      exp_q   <= exp_d;
      mism_q  <= mism_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      wc_q    <= wc_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = vld_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_data_in_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && emit && res.kind == KIND_DATA) |-> phase_q == PH_DATA)
    else $error("data byte emitted outside payload phase");
  a_sum_to_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && item_i.op == OP_BYTE && phase_q == PH_SUM) |=> phase_q == PH_HEADER)
    else $error("checksum byte did not return to header wait");
  a_ack_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && emit && res.verdict == V_ACCEPTED) |=> exp_q == $past(exp_q) + 8'd1)
    else $error("accepted packet did not advance sequence");
`endif

endmodule

>>> sv/xmodem_receiver.sv
// XMODEM checksum receiver top level: front decode, item queue, protocol back end.
// Depends on xmr_pkg, xmr_front, xmr_queue, xmr_back.
//
//  channel | dir | tdata                          | tuser
//  s_axis  | in  | rx_byte                        | command
//  m_axis  | out | data_byte,response,verdict,pkt | kind
//  cfg     | in  | cfg_idx_i selects register, cfg_data_i value, cfg_we_i strobe
//
// One item per cycle sustained while m_axis is not stalled; an item that yields a result
// raises m_axis_tvalid once it has passed the queue write and then the result register.
// A two-entry queue lets the input side keep running while a result waits.
// Reset: phase idle, expected sequence one, wait limits 10 and 1000 ticks.
// A stall on m_axis backs up through the queue to s_axis_tready.
module xmodem_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] data_byte, [9:8] response,
                                      // [12:10] verdict, [20:13] packet_number
  output logic        m_axis_tuser,   // [0] kind
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import xmr_pkg::*;

  logic        push;
  xmr_item_t   push_item;
  logic        pop;
  xmr_item_t   head;
  xmr_qstat_t  qstat;
  xmr_result_t res;

  xmr_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .qstat_i       (qstat),
    .push_o        (push),
    .item_o        (push_item)
  );

  xmr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_o      (head),
    .qstat_o     (qstat)
  );

  xmr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (head),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // Pack result fields, lowest first
  assign m_axis_tdata = {3'b000, res.packet_number, res.verdict, res.response, res.data_byte};
  assign m_axis_tuser = res.kind;

endmodule

>>> verif/tb.sv
// Self-checking bench for xmodem_receiver: start, byte and tick items in, data and responses out.
// Predicts each result from its own copy of the protocol state and checks it field by field.
// Depends on xmr_pkg and xmodem_receiver.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import xmr_pkg::*;

  // Command code that the block has to ignore
  localparam logic [1:0] CMD_RSVD = 2'd3;
  localparam int STUCK_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS = 100;
  localparam int REPORT_MAX = 20;

  typedef enum int {
    PKT_GOOD,
    PKT_BAD_SEQ,
    PKT_BAD_INV,
    PKT_BAD_SUM,
    PKT_STALL,
    PKT_CUT
  } pkt_flaw_e;

  typedef struct {
    logic [1:0] cmd;
    logic [7:0] data;
    bit         hold;  // wait for every pending result before sending
  } rx_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] rx_byte
  logic [1:0]  s_axis_tuser = '0;   // [1:0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [7:0] data_byte, [9:8] response,
                                    // [12:10] verdict, [20:13] packet_number
  logic        m_axis_tuser;        // [0] kind
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  rx_item_t    send_q[$];
  xmr_result_t expected_results[$];
  xmr_result_t head_result;
  rx_item_t    next_item;

  // Receiver state as predicted
  xmr_phase_e  rx_phase = PH_IDLE;
  logic [7:0]  exp_seq = 8'd1;
  logic        seq_bad = 1'b0;
  int unsigned byte_cnt = 0;
  logic [7:0]  chk_sum = '0;
  logic [15:0] tick_cnt = '0;
  logic [15:0] hdr_limit = HEADER_WAIT_RST;
  logic [15:0] byte_limit = BYTE_WAIT_RST;

  int  err_count = 0;
  int  results_seen = 0;
  int  pushed_items = 0;
  int  random_goal = 0;
  int  stuck_cycles = 0;
  int  src_gap = 0;
  int  src_calm = 0;
  int  snk_gap = 0;
  int  snk_calm = 0;

  xmodem_receiver dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  task automatic report_mismatch(string what, int unsigned got, int unsigned wanted);
    err_count++;
    if (err_count <= REPORT_MAX) begin
      $display("ERROR: result %0d %s: got %0h expected %0h", results_seen, what, got, wanted);
    end
  endtask

  // Response item with the packet number before any advance
  function automatic void expect_resp(xmr_rsp_e rsp, xmr_verdict_e verdict);
    xmr_result_t r;
    r = '0;
    r.kind = KIND_RESP;
    r.response = rsp;
    r.verdict = verdict;
    r.packet_number = exp_seq;
    expected_results.push_back(r);
  endfunction

  // Advance the predicted receiver by one accepted item
  function automatic void predict_step(logic [1:0] cmd, logic [7:0] b);
    xmr_result_t r;
    logic [15:0] limit;
    bit active;
    active = !(rx_phase inside {PH_IDLE, PH_DONE, PH_FAILED});
    case (cmd)
      CMD_START: begin
        exp_seq = 8'd1;
        seq_bad = 1'b0;
        byte_cnt = 0;
        chk_sum = '0;
        tick_cnt = '0;
        rx_phase = PH_HEADER;
        expect_resp(RSP_NAK, V_STARTED);
      end
      CMD_TICK: if (active) begin
        limit = (rx_phase == PH_HEADER) ? hdr_limit : byte_limit;
        if (tick_cnt != 16'hFFFF) tick_cnt++;
        if (tick_cnt >= limit) begin
          tick_cnt = '0;
          if (rx_phase == PH_HEADER) begin
            rx_phase = PH_FAILED;
            expect_resp(RSP_CAN, V_FAILED);
          end else begin
            rx_phase = PH_HEADER;
            expect_resp(RSP_CAN, V_REJECTED);
          end
        end
      end
      CMD_BYTE: if (active) begin
        tick_cnt = '0;
        case (rx_phase)
          PH_HEADER: begin
            if (b == SOH_BYTE) begin
              rx_phase = PH_SEQ;
              seq_bad = 1'b0;
              byte_cnt = 0;
              chk_sum = '0;
            end else if (b == EOT_BYTE) begin
              rx_phase = PH_DONE;
              expect_resp(RSP_ACK, V_COMPLETE);
            end else begin
              rx_phase = PH_FAILED;
              expect_resp(RSP_NAK, V_FAILED);
            end
          end
          PH_SEQ: begin
            seq_bad = (b != exp_seq);
            rx_phase = PH_INVSEQ;
          end
          PH_INVSEQ: begin
            if (b != ~exp_seq) seq_bad = 1'b1;
            byte_cnt = 0;
            chk_sum = '0;
            rx_phase = PH_DATA;
          end
          PH_DATA: begin
            r = '0;
            r.kind = KIND_DATA;
            r.data_byte = b;
            r.packet_number = exp_seq;
            expected_results.push_back(r);
            chk_sum = chk_sum + b;
            byte_cnt++;
            if (byte_cnt >= PAYLOAD_BYTES) rx_phase = PH_SUM;
          end
          PH_SUM: begin
            rx_phase = PH_HEADER;
            if (seq_bad || chk_sum != b) begin
              expect_resp(RSP_CAN, V_REJECTED);
            end else begin
              expect_resp(RSP_ACK, V_ACCEPTED);
              exp_seq = exp_seq + 8'd1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  endfunction

  // Idle cycles before the next item, with runs of back-to-back items
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 5);
  endfunction

  // Item driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_step(s_axis_tuser, s_axis_tdata);
        src_gap = draw_gap(src_calm);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (send_q.size() != 0 &&
                     !(send_q[0].hold && expected_results.size() != 0)) begin
          next_item = send_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= next_item.data;
          s_axis_tuser <= next_item.cmd;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      snk_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata, 0);
        end else begin
          head_result = expected_results.pop_front();
          if (m_axis_tuser !== head_result.kind)
            report_mismatch("kind", m_axis_tuser, head_result.kind);
          if (m_axis_tdata[7:0] !== head_result.data_byte)
            report_mismatch("data_byte", m_axis_tdata[7:0], head_result.data_byte);
          if (m_axis_tdata[9:8] !== head_result.response)
            report_mismatch("response", m_axis_tdata[9:8], head_result.response);
          if (m_axis_tdata[12:10] !== head_result.verdict)
            report_mismatch("verdict", m_axis_tdata[12:10], head_result.verdict);
          if (m_axis_tdata[20:13] !== head_result.packet_number)
            report_mismatch("packet_number", m_axis_tdata[20:13], head_result.packet_number);
          if (m_axis_tdata[23:21] !== 3'b000)
            report_mismatch("padding", m_axis_tdata[23:21], 0);
        end
        snk_gap = draw_gap(snk_calm);
      end
      if (snk_gap > 0) begin
        snk_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: work pending but no item moving on either side
  always @(posedge clk_i) begin
    if (rst_ni && (send_q.size() != 0 || s_axis_tvalid || expected_results.size() != 0) &&
        !(s_axis_tvalid && s_axis_tready) && !(m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("ERROR: no progress for %0d cycles", STUCK_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end else begin
      stuck_cycles = 0;
    end
  end

  function automatic void push_item(logic [1:0] cmd, logic [7:0] data, bit hold = 1'b0);
    rx_item_t it;
    it.cmd = cmd;
    it.data = data;
    it.hold = hold;
    send_q.push_back(it);
    pushed_items++;
  endfunction

  function automatic void push_ticks(int n);
    for (int i = 0; i < n; i++) push_item(CMD_TICK, 8'($urandom));
  endfunction

  // Ticks that stay below a wait limit
  function automatic int tick_room(int limit);
    if (limit <= 1) return 0;
    return (limit - 1 > 3) ? 3 : limit - 1;
  endfunction

  // Occasional harmless ticks and ignored commands between bytes
  function automatic void sprinkle(int room);
    if (room > 0 && $urandom_range(0, 7) == 0) push_ticks($urandom_range(1, room));
    if ($urandom_range(0, 63) == 0) push_item(CMD_RSVD, 8'($urandom));
  endfunction

  // One packet: SOH, sequence, inverted sequence, payload, checksum
  function automatic void push_packet(logic [7:0] seq, pkt_flaw_e flaw);
    logic [7:0] body [PAYLOAD_BYTES + 3];
    logic [7:0] sum;
    int stop_at;
    int room_b;
    sum = '0;
    room_b = tick_room(byte_limit);
    body[0] = seq;
    body[1] = ~seq;
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      body[i + 2] = 8'($urandom);
      sum += body[i + 2];
    end
    body[PAYLOAD_BYTES + 2] = sum;
    case (flaw)
      PKT_BAD_SEQ: body[0] ^= 8'($urandom_range(1, 255));
      PKT_BAD_INV: body[1] ^= 8'($urandom_range(1, 255));
      PKT_BAD_SUM: body[PAYLOAD_BYTES + 2] ^= 8'($urandom_range(1, 255));
      default: ;
    endcase
    stop_at = (flaw == PKT_STALL || flaw == PKT_CUT) ? $urandom_range(0, PAYLOAD_BYTES + 2) : -1;
    push_item(CMD_BYTE, SOH_BYTE);
    for (int k = 0; k < PAYLOAD_BYTES + 3; k++) begin
      if (k == stop_at) begin
        // a stall runs the byte wait out exactly; a cut leaves the packet open
        if (flaw == PKT_STALL) push_ticks((byte_limit == 0) ? 1 : byte_limit);
        return;
      end
      push_item(CMD_BYTE, body[k]);
      if (k < PAYLOAD_BYTES + 2 && k + 1 != stop_at) sprinkle(room_b);
    end
  endfunction

  // A transfer: start, up to n_pkts packets with random flaws, then an EOT, a bad header, a timeout or nothing
  function automatic void push_transfer(int n_pkts);
    logic [7:0] seq;
    logic [7:0] bad;
    pkt_flaw_e flaw;
    int pick;
    seq = 8'd1;
    push_item(CMD_START, 8'($urandom), $urandom_range(0, 3) == 0);
    for (int p = 0; p < n_pkts; p++) begin
      sprinkle(tick_room(hdr_limit));
      pick = $urandom_range(0, 9);
      case (pick)
        5: flaw = PKT_BAD_SEQ;
        6: flaw = PKT_BAD_INV;
        7: flaw = PKT_BAD_SUM;
        8: flaw = (byte_limit <= 64) ? PKT_STALL : PKT_BAD_SUM;
        9: flaw = PKT_CUT;
        default: flaw = PKT_GOOD;
      endcase
      push_packet(seq, flaw);
      if (flaw == PKT_CUT) return;
      if (flaw == PKT_GOOD) seq++;
    end
    sprinkle(tick_room(hdr_limit));
    pick = $urandom_range(0, 7);
    if (pick < 5) begin
      push_item(CMD_BYTE, EOT_BYTE);
    end else if (pick == 5) begin
      do bad = 8'($urandom); while (bad == SOH_BYTE || bad == EOT_BYTE);
      push_item(CMD_BYTE, bad);
    end else if (pick == 6 && hdr_limit <= 64) begin
      push_ticks((hdr_limit == 0) ? 1 : hdr_limit);
    end
    // stray items after the end are ignored, otherwise they hit the header wait
    if ($urandom_range(0, 3) == 0) push_item(2'($urandom_range(1, 3)), 8'($urandom));
  endfunction

  // Wait until every item is sent and every result is back, then let the pipe empty
  task automatic settle();
    do @(negedge clk_i);
    while (send_q.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    if (idx == CFG_HEADER_WAIT) hdr_limit = val;
    else byte_limit = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // At least one transfer per limit setting; the item budget is shared across phases
  task automatic run_random_phase(logic [15:0] hdr, logic [15:0] byt);
    settle();
    write_reg(CFG_HEADER_WAIT, hdr);
    write_reg(CFG_BYTE_WAIT, byt);
    random_goal += PHASE_ITEMS;
    do push_transfer($urandom_range(0, 1));
    while (pushed_items < random_goal);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: ignored items while idle, header timeout at reset limit,
    // items after failure, bad header, restart, EOT, items after completion
    push_item(CMD_BYTE, SOH_BYTE);
    push_item(CMD_TICK, 8'hFF);
    push_item(CMD_RSVD, 8'h00);
    push_item(CMD_START, 8'h00);
    push_ticks(9);
    push_item(CMD_RSVD, 8'hFF);
    push_item(CMD_TICK, 8'h00);
    push_item(CMD_TICK, 8'h5A);
    push_item(CMD_BYTE, EOT_BYTE);
    push_item(CMD_START, 8'hFF);
    push_item(CMD_BYTE, 8'hFF);
    push_item(CMD_START, 8'h01);
    push_item(CMD_START, 8'hA5);
    push_item(CMD_BYTE, EOT_BYTE);
    push_item(CMD_BYTE, SOH_BYTE);
    push_item(CMD_START, 8'h00, 1'b1);
    push_item(CMD_BYTE, 8'h00);

    // Zero limits: the first tick of any wait times out
    settle();
    write_reg(CFG_HEADER_WAIT, 16'd0);
    write_reg(CFG_BYTE_WAIT, 16'd0);
    push_item(CMD_START, 8'h3C);
    push_item(CMD_TICK, 8'hC3);
    push_item(CMD_START, 8'h00);
    push_item(CMD_BYTE, SOH_BYTE);
    push_item(CMD_TICK, 8'h00);
    push_item(CMD_TICK, 8'hFF);

    // Random transfers under several limit settings
    random_goal = pushed_items;
    run_random_phase(16'd1, 16'd1);
    run_random_phase(16'd2, 16'd5);
    run_random_phase(16'hFFFF, 16'd40);
    run_random_phase(16'd12, 16'hFFFF);
    run_random_phase(16'($urandom_range(1, 20)), 16'($urandom_range(1, 20)));
    run_random_phase(HEADER_WAIT_RST, BYTE_WAIT_RST);

    settle();
    if (expected_results.size() != 0)
      report_mismatch("results never seen", expected_results.size(), 0);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
